FILE: design/sirt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants for the radix text converter
// Widths, character codes, the reciprocal table and the control structs that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package sirt_pkg;

   // Configurable sizes.
   localparam int MAX_RADIX   = 16;
   localparam int VALUE_WIDTH = 32;

   // Fixed field and register widths.
   localparam int NUMBER_WIDTH    = 32;
   localparam int CHAR_WIDTH      = 8;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_ADDR_WIDTH  = 4;
   localparam int DIGIT_SLOTS     = 16;

   // Derived widths.
   localparam int RADIX_WIDTH       = $clog2(MAX_RADIX + 1);
   localparam int DIGIT_WIDTH       = $clog2(MAX_RADIX);
   localparam int REM_WIDTH         = RADIX_WIDTH + 1;
   localparam int COUNT_WIDTH       = $clog2(VALUE_WIDTH + 1);
   localparam int PRODUCT_WIDTH     = 2 * VALUE_WIDTH;
   localparam int RECIP_INDEX_WIDTH = $clog2(DIGIT_SLOTS + 1);

   // Register selection: bit 3 of the byte address picks the register.
   localparam int          REG_SELECT_BIT = 3;
   localparam logic        REG_CHARS_LOW  = 1'b0;
   localparam logic        REG_CHARS_HIGH = 1'b1;

   // Character codes.
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;

   // floor(2^VALUE_WIDTH / r) for every radix r; entries 0 and 1 are never used.
   localparam logic [PRODUCT_WIDTH:0] RECIP_ONE = (PRODUCT_WIDTH + 1)'(1) << VALUE_WIDTH;
   localparam logic [VALUE_WIDTH-1:0] RECIP_TABLE [DIGIT_SLOTS + 1] = '{
      '0, '0,
      VALUE_WIDTH'(RECIP_ONE / 2),  VALUE_WIDTH'(RECIP_ONE / 3),
      VALUE_WIDTH'(RECIP_ONE / 4),  VALUE_WIDTH'(RECIP_ONE / 5),
      VALUE_WIDTH'(RECIP_ONE / 6),  VALUE_WIDTH'(RECIP_ONE / 7),
      VALUE_WIDTH'(RECIP_ONE / 8),  VALUE_WIDTH'(RECIP_ONE / 9),
      VALUE_WIDTH'(RECIP_ONE / 10), VALUE_WIDTH'(RECIP_ONE / 11),
      VALUE_WIDTH'(RECIP_ONE / 12), VALUE_WIDTH'(RECIP_ONE / 13),
      VALUE_WIDTH'(RECIP_ONE / 14), VALUE_WIDTH'(RECIP_ONE / 15),
      VALUE_WIDTH'(RECIP_ONE / 16)
   };

   // The digit characters in use, character 0 in the lowest byte.
   typedef logic [MAX_RADIX-1:0][CHAR_WIDTH-1:0] char_set_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;        // capture the input value and its sign
      logic mul;         // multiply the magnitude by the reciprocal
      logic div;         // correct the quotient and push one digit
      logic emit_sign;   // load the minus sign into the output register
      logic emit_digit;  // pop one digit into the output register
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic quotient_zero;
      logic last_digit;
      logic negative;
   } dp_status_type;

endpackage

FILE: design/sirt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_if: valid/ready channels of the radix text converter
// The request channel carries one signed value, the response channel one
// character of its text.
// ----------------------------------------------------------------------------
interface sirt_req_if;
   import sirt_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [NUMBER_WIDTH-1:0] number_value;

   modport source (output valid, output number_value, input ready);
   modport sink   (input valid, input number_value, output ready);
endinterface

interface sirt_rsp_if;
   import sirt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] text_char;
   logic                  is_last_char;

   modport source (output valid, output text_char, output is_last_char, input ready);
   modport sink   (input valid, input text_char, input is_last_char, output ready);
endinterface

FILE: design/sirt_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_csr: digit character registers and base check
// Holds the two 64-bit character registers behind an APB-style port and
// works out the radix, registered, with zero standing for an invalid base.
// ----------------------------------------------------------------------------
module sirt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sirt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [sirt_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [sirt_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output sirt_pkg::char_set_type              digit_chars,
   output logic [sirt_pkg::RADIX_WIDTH-1:0]    radix
);
   import sirt_pkg::*;

   logic [CSR_DATA_WIDTH-1:0]                    chars_low_ff, chars_low_in;
   logic [CSR_DATA_WIDTH-1:0]                    chars_high_ff, chars_high_in;
   logic [RADIX_WIDTH-1:0]                       radix_ff, radix_in;
   logic [DIGIT_SLOTS-1:0][CHAR_WIDTH-1:0]       all_chars;
   logic [MAX_RADIX-1:0]                         used;
   logic                                         bad_char;
   logic [RADIX_WIDTH-1:0]                       used_count;
   logic                                         write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite;
   assign all_chars  = {chars_high_ff, chars_low_ff};

   always_comb begin
      chars_low_in  = chars_low_ff;
      chars_high_in = chars_high_ff;
      if (write_hit) begin
         case (csr_paddr[REG_SELECT_BIT])
            REG_CHARS_LOW:  chars_low_in  = csr_pwdata;
            REG_CHARS_HIGH: chars_high_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[REG_SELECT_BIT])
         REG_CHARS_LOW:  csr_prdata = chars_low_ff;
         REG_CHARS_HIGH: csr_prdata = chars_high_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // A character is used when it and every one before it are nonzero.
   always_comb begin
      used[0] = all_chars[0] != '0;
      for (int i = 1; i < MAX_RADIX; i++) begin
         used[i] = used[i-1] && (all_chars[i] != '0);
      end
   end

   always_comb begin
      bad_char = 1'b0;
      for (int i = 0; i < MAX_RADIX; i++) begin
         if (used[i] && (all_chars[i] == CH_PLUS || all_chars[i] == CH_MINUS)) begin
            bad_char = 1'b1;
         end
         for (int j = i + 1; j < MAX_RADIX; j++) begin
            if (used[j] && all_chars[i] == all_chars[j]) begin
               bad_char = 1'b1;
            end
         end
      end
   end

   assign used_count = RADIX_WIDTH'($countones(used));
   assign radix_in   = (used_count >= RADIX_WIDTH'(2) && !bad_char) ? used_count : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
         radix_ff      <= '0;
      end else begin
         chars_low_ff  <= chars_low_in;
         chars_high_ff <= chars_high_in;
         radix_ff      <= radix_in;
      end
   end

   assign digit_chars = all_chars[MAX_RADIX-1:0];
   assign radix       = radix_ff;

endmodule

FILE: design/sirt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_dp: datapath of the radix text converter
// Division by the radix through a reciprocal multiply and a small remainder
// correction, a digit stack and the output character register.
// ----------------------------------------------------------------------------
module sirt_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sirt_pkg::dp_cmd_type                   cmd,
   output sirt_pkg::dp_status_type                status,
   input  logic signed [sirt_pkg::NUMBER_WIDTH-1:0] number_value,
   input  logic [sirt_pkg::RADIX_WIDTH-1:0]       radix,
   input  sirt_pkg::char_set_type                 digit_chars,
   output logic [sirt_pkg::CHAR_WIDTH-1:0]        text_char,
   output logic                                   is_last_char
);
   import sirt_pkg::*;

   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [PRODUCT_WIDTH-1:0] prod_ff, prod_in;
   logic [DIGIT_WIDTH-1:0]   stack_ff [VALUE_WIDTH];
   logic [DIGIT_WIDTH-1:0]   stack_in [VALUE_WIDTH];
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [CHAR_WIDTH-1:0]    text_char_ff, text_char_in;
   logic                     is_last_ff, is_last_in;

   logic [VALUE_WIDTH-1:0]   raw_value;
   logic [VALUE_WIDTH-1:0]   recip;
   logic [VALUE_WIDTH-1:0]   quot_est;
   logic [REM_WIDTH-1:0]     back_low;
   logic [REM_WIDTH-1:0]     rem_est;
   logic [REM_WIDTH-1:0]     radix_ext;
   logic                     fix;
   logic [VALUE_WIDTH-1:0]   quotient;
   logic [DIGIT_WIDTH-1:0]   digit_value;

   assign raw_value = number_value[VALUE_WIDTH-1:0];
   assign recip     = RECIP_TABLE[RECIP_INDEX_WIDTH'(radix)];
   assign radix_ext = REM_WIDTH'(radix);

   // The estimate is low by at most one, so the true remainder stays below
   // twice the radix and only its low bits need computing.
   assign quot_est    = prod_ff[PRODUCT_WIDTH-1:VALUE_WIDTH];
   assign back_low    = REM_WIDTH'(quot_est[REM_WIDTH-1:0] * radix_ext);
   assign rem_est     = mag_ff[REM_WIDTH-1:0] - back_low;
   assign fix         = rem_est >= radix_ext;
   assign quotient    = quot_est + VALUE_WIDTH'(fix);
   assign digit_value = DIGIT_WIDTH'(fix ? (rem_est - radix_ext) : rem_est);

   assign status.quotient_zero = quotient == '0;
   assign status.last_digit    = count_ff == COUNT_WIDTH'(1);
   assign status.negative      = neg_ff;

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      stack_in     = stack_ff;
      count_in     = count_ff;
      text_char_in = text_char_ff;
      is_last_in   = is_last_ff;
      if (cmd.load) begin
         // The most negative value negates to itself, which is its magnitude.
         neg_in   = raw_value[VALUE_WIDTH-1];
         mag_in   = raw_value[VALUE_WIDTH-1] ? (~raw_value + VALUE_WIDTH'(1)) : raw_value;
         count_in = '0;
      end
      if (cmd.mul) begin
         prod_in = mag_ff * recip;
      end
      if (cmd.div) begin
         mag_in      = quotient;
         stack_in[0] = digit_value;
         for (int i = 1; i < VALUE_WIDTH; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
         count_in = count_ff + COUNT_WIDTH'(1);
      end
      if (cmd.emit_sign) begin
         text_char_in = CH_MINUS;
         is_last_in   = 1'b0;
      end
      if (cmd.emit_digit) begin
         text_char_in = digit_chars[stack_ff[0]];
         is_last_in   = count_ff == COUNT_WIDTH'(1);
         for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      stack_ff     <= stack_in;
      text_char_ff <= text_char_in;
      is_last_ff   <= is_last_in;
   end

   assign text_char    = text_char_ff;
   assign is_last_char = is_last_ff;

   // The digit stack never holds more digits than the value has bits.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(VALUE_WIDTH))
      else $error("digit count beyond the value width");

   // The corrected remainder is always a digit of the radix.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> (REM_WIDTH'(digit_value) < radix_ext))
      else $error("remainder correction produced a digit outside the radix");

   // A digit is only popped when one is held, and the final one is flagged.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (count_ff != '0))
      else $error("digit popped from an empty stack");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && count_ff == COUNT_WIDTH'(1)) |=> is_last_ff)
      else $error("final digit not marked as last");

endmodule

FILE: design/sirt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_ctrl: controller of the radix text converter
// Sequences capture, digit extraction and character output, and owns the
// request ready and the response valid.
// ----------------------------------------------------------------------------
module sirt_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [sirt_pkg::RADIX_WIDTH-1:0]    radix,
   output sirt_pkg::dp_cmd_type                cmd,
   input  sirt_pkg::dp_status_type             status
);
   import sirt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (radix == '0) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (!status.quotient_zero) begin
               state_in = ST_MUL;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = cmd.emit_sign || cmd.emit_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/signed_integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text: signed value to text in a configurable base
// Converts one signed 32-bit value per request transaction into a run of
// character bytes, one response transaction per character.
// ----------------------------------------------------------------------------
// Usage. Program the digit characters through the APB port: the register at
// byte address 0 holds characters 0 to 7 and the one at address 8 holds
// characters 8 to 15, lowest byte first. The radix is the number of leading
// nonzero characters; a base with fewer than two characters, a plus or minus
// sign among them, or a repeated character is invalid, and a request taken
// under an invalid base produces no response at all.
// A request transaction carries number_value. The block replies with '-' for
// a negative value and then the digits, most significant first, one response
// transaction each, with is_last_char set on the final character.
// Each value is captured, then every digit passes through the reciprocal
// multiplier and then the remainder correction, and finally the sign, if
// any, and the digits go out, the controller waiting while the output
// stalls. A new request is taken as soon as the last character sits in
// the output register.
// Reset (synchronous, active high) clears the character registers, so the
// base is invalid until it is programmed, and drops any transaction in hand.
// When the receiver stalls, the output register holds its character and the
// controller waits; nothing is lost.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text (
   input  logic                                clock,
   input  logic                                reset,
   sirt_req_if.sink                            req_bus,
   sirt_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sirt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [sirt_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [sirt_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import sirt_pkg::*;

   // Configuration seen by the rest of the block.
   char_set_type           digit_chars;
   logic [RADIX_WIDTH-1:0] radix;

   // Command and status between the controller and the datapath.
   dp_cmd_type             cmd;
   dp_status_type          status;

   // Character registers and the registered base check. The radix is worked out
   // from the character registers and then registered itself.
   sirt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .digit_chars (digit_chars),
      .radix       (radix)
   );

   // The controller owns both handshakes; the datapath holds the payload.
   sirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .radix     (radix),
      .cmd       (cmd),
      .status    (status)
   );

   sirt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .number_value (req_bus.number_value),
      .radix        (radix),
      .digit_chars  (digit_chars),
      .text_char    (rsp_bus.text_char),
      .is_last_char (rsp_bus.is_last_char)
   );

endmodule

FILE: bench/sirt_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_text_checker: response checker for the radix text converter
// Follows the character registers through the APB port, works out the text of
// every accepted value and compares each response transaction with the
// oldest character that is still due.
// ----------------------------------------------------------------------------
module sirt_text_checker (
   input  logic                                clock,
   input  logic                                reset,
   sirt_req_if                                 req_bus,
   sirt_rsp_if                                 rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sirt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [sirt_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                                csr_pready,
   output int unsigned                         failure_count,
   output int unsigned                         chars_outstanding
);
   import sirt_pkg::*;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] text_char;
      logic                  is_last_char;
   } text_char_type;

   text_char_type pending_chars [$];
   char_set_type  digit_set;
   int unsigned   mismatch_total = 0;

   function automatic void note_failure(input string what);
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT) begin
         $display("[%0t] text checker: %s", $realtime, what);
      end
   endfunction

   // Radix of the programmed base, or zero when the base is unusable.
   function automatic int unsigned base_radix();
      int unsigned count;
      count = 0;
      while (count < MAX_RADIX && digit_set[count] != '0) begin
         count++;
      end
      if (count < 2) begin
         return 0;
      end
      for (int unsigned i = 0; i < count; i++) begin
         if (digit_set[i] == CH_PLUS || digit_set[i] == CH_MINUS) begin
            return 0;
         end
         for (int unsigned k = i + 1; k < count; k++) begin
            if (digit_set[k] == digit_set[i]) begin
               return 0;
            end
         end
      end
      return count;
   endfunction

   // Queues the characters that one value must produce.
   function automatic void predict_text(input logic signed [NUMBER_WIDTH-1:0] number_value);
      int unsigned           radix;
      logic [VALUE_WIDTH-1:0] raw;
      logic [VALUE_WIDTH:0]  magnitude;
      logic                  negative;
      logic [CHAR_WIDTH-1:0] digits [$];
      radix = base_radix();
      if (radix == 0) begin
         return;
      end
      raw      = number_value[VALUE_WIDTH-1:0];
      negative = raw[VALUE_WIDTH-1];
      // One bit wider than the value, so the most negative value has room.
      magnitude = negative ? ({1'b1, {VALUE_WIDTH{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
      do begin
         digits.push_front(digit_set[int'(magnitude % radix)]);
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      if (negative) begin
         pending_chars.push_back('{text_char: CH_MINUS, is_last_char: 1'b0});
      end
      foreach (digits[i]) begin
         pending_chars.push_back('{text_char: digits[i],
                                   is_last_char: (i == digits.size() - 1)});
      end
   endfunction

   always @(posedge clock) begin : watch
      text_char_type due;
      if (reset) begin
         digit_set = '0;
         pending_chars.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[REG_SELECT_BIT] == REG_CHARS_LOW) begin
               digit_set[7:0] = csr_pwdata;
            end else begin
               digit_set[15:8] = csr_pwdata;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_chars.size() == 0) begin
               note_failure($sformatf("unexpected character %h, last flag %b",
                                      rsp_bus.text_char, rsp_bus.is_last_char));
            end else begin
               due = pending_chars.pop_front();
               if (rsp_bus.text_char !== due.text_char ||
                   rsp_bus.is_last_char !== due.is_last_char) begin
                  note_failure($sformatf("character %h last %b, expected %h last %b",
                                         rsp_bus.text_char, rsp_bus.is_last_char,
                                         due.text_char, due.is_last_char));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_text(req_bus.number_value);
         end
      end
      failure_count     <= mismatch_total;
      chars_outstanding <= pending_chars.size();
   end

endmodule

FILE: bench/tb_signed_integer_to_radix_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_integer_to_radix_text: testbench for the radix text converter
// Programs a series of digit sets, valid and broken, and feeds signed values
// through the request channel with bursty traffic and a stalling receiver.
// A separate checker predicts every character; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_text;
   import sirt_pkg::*;

   // Timing of the run. The settle time only has to cover a value taken under
   // a broken base, which the block drops from its multiply state without
   // leaving a character behind; it is kept generous.
   localparam int unsigned CYCLE_LIMIT       = 800_000;
   localparam int unsigned SETTLE_CYCLES     = 128;
   localparam int unsigned LONG_STALL_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES     = 8;
   localparam int unsigned VALUES_PER_PHASE  = 30;
   localparam int unsigned BROKEN_VALUES     = 6;

   // Register addresses: bit REG_SELECT_BIT of the byte address selects the register.
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_CHARS_LOW  =
      CSR_ADDR_WIDTH'(REG_CHARS_LOW) << REG_SELECT_BIT;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_CHARS_HIGH =
      CSR_ADDR_WIDTH'(REG_CHARS_HIGH) << REG_SELECT_BIT;

   // Digit sets used by the directed part, character 0 in the lowest byte.
   localparam logic [CSR_DATA_WIDTH-1:0] DECIMAL_LOW  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_WIDTH-1:0] DECIMAL_HIGH = 64'h0000_0000_0000_3938;
   localparam logic [CSR_DATA_WIDTH-1:0] HEX_HIGH     = 64'h4645_4443_4241_3938;

   localparam logic signed [NUMBER_WIDTH-1:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [NUMBER_WIDTH-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

   // Ways of spoiling a randomly drawn digit set.
   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_PLUS,
      FLAW_MINUS,
      FLAW_REPEAT,
      FLAW_SHORT
   } base_flaw_type;

   // Behaviours of the response receiver.
   typedef enum int unsigned {
      SINK_ALWAYS,
      SINK_HALF,
      SINK_SPARSE,
      SINK_PERIODIC
   } sink_mode_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;
   int unsigned               failure_count;
   int unsigned               chars_outstanding;
   int unsigned               cycle_count = 0;
   int unsigned               burst_left = 0;
   logic                      long_stall_request = 1'b0;

   sirt_req_if req_bus ();
   sirt_rsp_if rsp_bus ();

   signed_integer_to_radix_text dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sirt_text_checker text_checker (
      .clock             (clock),
      .reset             (reset),
      .req_bus           (req_bus),
      .rsp_bus           (rsp_bus),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .failure_count     (failure_count),
      .chars_outstanding (chars_outstanding)
   );

   always #4 clock = ~clock;

   // Watchdog: a run that has not finished by now has hung somewhere.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // The receiver changes its manner after each span of random length. Once in the run
   // the stimulus asks it to hold off for a long stretch, during which the
   // block fills up and must stall its request channel.
   initial begin : receiver
      sink_mode_type mode;
      int unsigned   span;
      logic          stall_taken;
      stall_taken   = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = sink_mode_type'($urandom_range(SINK_ALWAYS, SINK_PERIODIC));
         span = $urandom_range(8, 120);
         for (int unsigned k = 0; k < span; k++) begin
            @(posedge clock);
            if (long_stall_request && !stall_taken) begin
               stall_taken = 1'b1;
               rsp_bus.ready <= 1'b0;
               repeat (LONG_STALL_CYCLES) @(posedge clock);
            end else begin
               case (mode)
                  SINK_ALWAYS: begin
                     rsp_bus.ready <= 1'b1;
                  end
                  SINK_HALF: begin
                     rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                  end
                  SINK_SPARSE: begin
                     rsp_bus.ready <= ($urandom_range(0, 4) == 0);
                  end
                  default: begin
                     rsp_bus.ready <= (k % 3 == 2);
                  end
               endcase
            end
         end
      end
   end

   // One APB write: a setup phase and then an access phase. The select is
   // left high so that writes can follow one another directly; the caller
   // lowers it after the last one.
   task automatic write_register(input logic [CSR_ADDR_WIDTH-1:0] address,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= address;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Stops offering values and waits until every predicted character has
   // been accepted by the receiver.
   task automatic finish_outstanding();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (chars_outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Reprogramming is only safe on an idle block. A value taken under a
   // broken base leaves no character behind, so the block may still be busy
   // with it after the last character; the settle time covers that.
   task automatic change_digit_set(input logic [CSR_DATA_WIDTH-1:0] chars_low,
                                   input logic [CSR_DATA_WIDTH-1:0] chars_high);
      finish_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(ADDR_CHARS_LOW, chars_low);
      write_register(ADDR_CHARS_HIGH, chars_high);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offers one value and returns at the edge where it is accepted. Values
   // go out in bursts; between bursts there is usually a gap, sometimes none.
   task automatic offer_value(input logic signed [NUMBER_WIDTH-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.number_value <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Mostly small magnitudes and values of random length, so that texts of
   // every size turn up, with full-width values and the extremes mixed in.
   function automatic logic signed [NUMBER_WIDTH-1:0] random_value();
      logic [NUMBER_WIDTH-1:0] bits;
      case ($urandom_range(0, 7))
         0: begin
            bits = $urandom_range(0, 80) - 40;
         end
         1: begin
            case ($urandom_range(0, 4))
               0:       bits = MOST_NEGATIVE;
               1:       bits = MOST_POSITIVE;
               2:       bits = '0;
               3:       bits = '1;
               default: bits = MOST_NEGATIVE + 1;
            endcase
         end
         2, 3: begin
            bits = $urandom;
         end
         default: begin
            bits = $urandom >> $urandom_range(0, NUMBER_WIDTH - 1);
            if ($urandom_range(0, 1) == 1) begin
               bits = -bits;
            end
         end
      endcase
      return bits;
   endfunction

   // Draws a digit set of the given radix with distinct characters that are
   // neither sign. The slot after the last digit is zero and the slots beyond
   // it hold rubbish, which the block must ignore. A flaw, if asked for,
   // then spoils the set.
   function automatic void random_digit_set(input int unsigned radix,
                                            input base_flaw_type flaw,
                                            output logic [CSR_DATA_WIDTH-1:0] chars_low,
                                            output logic [CSR_DATA_WIDTH-1:0] chars_high);
      char_set_type          chars;
      logic [255:0]          taken;
      logic [CHAR_WIDTH-1:0] candidate;
      int unsigned           first;
      int unsigned           second;
      taken = '0;
      for (int unsigned i = 0; i < MAX_RADIX; i++) begin
         if (i < radix) begin
            do begin
               candidate = CHAR_WIDTH'($urandom_range(1, 255));
            end while (candidate == CH_PLUS || candidate == CH_MINUS || taken[candidate]);
            taken[candidate] = 1'b1;
            chars[i] = candidate;
         end else if (i == radix) begin
            chars[i] = '0;
         end else begin
            chars[i] = CHAR_WIDTH'($urandom_range(0, 255));
         end
      end
      case (flaw)
         FLAW_PLUS: begin
            chars[$urandom_range(0, radix - 1)] = CH_PLUS;
         end
         FLAW_MINUS: begin
            chars[$urandom_range(0, radix - 1)] = CH_MINUS;
         end
         FLAW_REPEAT: begin
            first  = $urandom_range(0, radix - 2);
            second = $urandom_range(first + 1, radix - 1);
            chars[second] = chars[first];
         end
         FLAW_SHORT: begin
            chars[$urandom_range(0, 1)] = '0;
         end
         default: begin
         end
      endcase
      {chars_high, chars_low} = chars;
   endfunction

   initial begin : stimulus
      logic [CSR_DATA_WIDTH-1:0] chars_low;
      logic [CSR_DATA_WIDTH-1:0] chars_high;
      int unsigned               radix;
      base_flaw_type             flaw;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.number_value = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The registers come out of reset empty, so the base is unusable and
      // these values must produce no characters at all.
      offer_value(5);
      offer_value(-7);

      // Decimal: zero, a one-digit negative (no stray leading zero), the
      // first two-digit values and both ends of the range.
      change_digit_set(DECIMAL_LOW, DECIMAL_HIGH);
      offer_value(0);
      offer_value(7);
      offer_value(-3);
      offer_value(10);
      offer_value(-10);
      offer_value(MOST_POSITIVE);
      offer_value(MOST_NEGATIVE);
      offer_value(-1);

      // Binary: the most negative value gives the longest text of all.
      change_digit_set(64'h3130, '0);
      offer_value(MOST_NEGATIVE);
      offer_value(MOST_POSITIVE);
      offer_value(1);
      offer_value(-1);

      // All sixteen slots in use.
      change_digit_set(DECIMAL_LOW, HEX_HIGH);
      offer_value(MOST_NEGATIVE);
      offer_value(MOST_POSITIVE);
      offer_value(-15);
      offer_value(255);

      // Broken bases, one value each: a single character, a plus sign, a
      // minus sign, a repeat within one register, a repeat across the two
      // registers and both registers full of ones.
      change_digit_set(64'h30, '0);
      offer_value(42);
      change_digit_set(64'h2B32_3130, '0);
      offer_value(42);
      change_digit_set(64'h3231_2D30, '0);
      offer_value(-42);
      change_digit_set(64'h0031_3332_3130, '0);
      offer_value(42);
      change_digit_set(DECIMAL_LOW, 64'h3039);
      offer_value(42);
      change_digit_set('1, '1);
      offer_value(-42);

      // Signs beyond the first zero byte are never used, so base four holds.
      change_digit_set(64'h2B2B_2B00_3332_3130, 64'h2D2D_2D2D_2D2D_2D2D);
      offer_value(-17);
      offer_value(255);

      // Random part. The first phase uses base two, which makes long texts,
      // and brings on the receiver's long hold-off; the second uses the full
      // sixteen characters. Every third phase is followed by a short run
      // under a spoilt base.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            radix = 2;
         end else if (phase == 1) begin
            radix = MAX_RADIX;
         end else begin
            radix = $urandom_range(2, MAX_RADIX);
         end
         random_digit_set(radix, FLAW_NONE, chars_low, chars_high);
         change_digit_set(chars_low, chars_high);
         if (phase == 0) begin
            long_stall_request = 1'b1;
         end
         repeat (VALUES_PER_PHASE) offer_value(random_value());
         if (phase % 3 == 2) begin
            flaw = base_flaw_type'($urandom_range(FLAW_PLUS, FLAW_SHORT));
            random_digit_set($urandom_range(2, MAX_RADIX), flaw, chars_low, chars_high);
            change_digit_set(chars_low, chars_high);
            repeat (BROKEN_VALUES) offer_value(random_value());
         end
      end

      // Drain, then leave time for any stray character to show itself.
      finish_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failure_count == 0 && chars_outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: signed_integer_to_radix_text.f
design/sirt_pkg.sv
design/sirt_if.sv
design/sirt_csr.sv
design/sirt_dp.sv
design/sirt_ctrl.sv
design/signed_integer_to_radix_text.sv
bench/sirt_text_checker.sv
bench/tb_signed_integer_to_radix_text.sv
